[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// implication checked in the following cycle, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/nrmc_pkg.sv]
// ----------------------------------------------------------------------------
// nrmc_pkg
// types, constants and helpers of the rmc time and date parser
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam logic [7:0] SEP_CHAR   = 8'h2C;  // ','
    localparam logic [7:0] ZERO_CHAR  = 8'h30;  // '0'
    localparam logic [7:0] NINE_CHAR  = 8'h39;  // '9'
    localparam logic [3:0] FIELD_CAP  = 4'd12;
    localparam logic [3:0] MIN_COMMAS = 4'd9;   // ten fields
    localparam logic [2:0] DIGITS     = 3'd6;
    localparam logic [3:0] TIME_FIELD = 4'd1;
    localparam logic [3:0] DATE_FIELD = 4'd9;
    localparam int         NDIGITS    = 6;

    typedef logic [3:0] digit_t;
    typedef digit_t [NDIGITS-1:0] digits_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic [6:0] day;
        logic [6:0] month;
        logic [6:0] year;
    } result_t;

    // two decimal digits to binary, kept to seven bits
    function automatic logic [6:0] pair_value(input digit_t hi, input digit_t lo);
        logic [6:0] sum;
        sum = {3'b000, hi} * 7'd10 + {3'b000, lo};
        return sum;
    endfunction

endpackage

[rtl/core/nrmc_stream_if.sv]
// ----------------------------------------------------------------------------
// nrmc_stream_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
interface nrmc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/nrmc_field_tracker.sv]
// ----------------------------------------------------------------------------
// nrmc_field_tracker
// sentence state: field count, digit capture and the result of a sentence
// ----------------------------------------------------------------------------
module nrmc_field_tracker #(
    parameter int MAX_LEN = 127
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  nrmc_pkg::char_t   item,
    output nrmc_pkg::result_t res
);
    localparam int SeenW = $clog2(MAX_LEN + 1);

    logic [3:0]        field_reg, field_next;
    logic [2:0]        cif_reg, cif_next;
    logic [SeenW-1:0]  seen_reg, seen_next;
    logic              time_len_reg, time_len_next;
    logic              date_len_reg, date_len_next;
    logic              bad_reg, bad_next;
    nrmc_pkg::digits_t time_reg, time_next;
    nrmc_pkg::digits_t date_reg, date_next;

    logic              take;
    logic              is_digit;
    nrmc_pkg::digit_t  value;
    logic              ok;

    assign take     = seen_reg < SeenW'(MAX_LEN);
    assign is_digit = (item.ch >= nrmc_pkg::ZERO_CHAR) && (item.ch <= nrmc_pkg::NINE_CHAR);
    assign value    = 4'(item.ch - nrmc_pkg::ZERO_CHAR);

    always_comb
    begin
        field_next    = field_reg;
        cif_next      = cif_reg;
        seen_next     = seen_reg;
        time_len_next = time_len_reg;
        date_len_next = date_len_reg;
        bad_next      = bad_reg;
        time_next     = time_reg;
        date_next     = date_reg;
        if (take)
        begin
            seen_next = seen_reg + 1'b1;
            if (item.ch == nrmc_pkg::SEP_CHAR)
            begin
                if (field_reg < nrmc_pkg::FIELD_CAP)
                begin
                    field_next = field_reg + 1'b1;
                end
                cif_next = '0;
            end
            else if (cif_reg < nrmc_pkg::DIGITS)
            begin
                if (field_reg == nrmc_pkg::TIME_FIELD)
                begin
                    time_next[cif_reg] = value;
                    if (!is_digit)
                    begin
                        bad_next = 1'b1;
                    end
                    if (cif_reg == nrmc_pkg::DIGITS - 3'd1)
                    begin
                        time_len_next = 1'b1;
                    end
                end
                else if (field_reg == nrmc_pkg::DATE_FIELD)
                begin
                    date_next[cif_reg] = value;
                    if (!is_digit)
                    begin
                        bad_next = 1'b1;
                    end
                    if (cif_reg == nrmc_pkg::DIGITS - 3'd1)
                    begin
                        date_len_next = 1'b1;
                    end
                end
                cif_next = cif_reg + 1'b1;
            end
        end
    end

    assign ok = (field_next >= nrmc_pkg::MIN_COMMAS) && time_len_next && date_len_next
                && !bad_next;

    always_comb
    begin
        res = '0;
        if (ok)
        begin
            res.ok      = 1'b1;
            res.hours   = nrmc_pkg::pair_value(time_next[0], time_next[1]);
            res.minutes = nrmc_pkg::pair_value(time_next[2], time_next[3]);
            res.seconds = nrmc_pkg::pair_value(time_next[4], time_next[5]);
            res.day     = nrmc_pkg::pair_value(date_next[0], date_next[1]);
            res.month   = nrmc_pkg::pair_value(date_next[2], date_next[3]);
            res.year    = nrmc_pkg::pair_value(date_next[4], date_next[5]);
        end
    end

    // control state; cleared at the end of every sentence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg    <= '0;
            cif_reg      <= '0;
            seen_reg     <= '0;
            time_len_reg <= 1'b0;
            date_len_reg <= 1'b0;
            bad_reg      <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                field_reg    <= '0;
                cif_reg      <= '0;
                seen_reg     <= '0;
                time_len_reg <= 1'b0;
                date_len_reg <= 1'b0;
                bad_reg      <= 1'b0;
            end
            else
            begin
                field_reg    <= field_next;
                cif_reg      <= cif_next;
                seen_reg     <= seen_next;
                time_len_reg <= time_len_next;
                date_len_reg <= date_len_next;
                bad_reg      <= bad_next;
            end
        end
    end

    // digits are only read once all six of a field were written this sentence
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            time_reg <= time_next;
            date_reg <= date_next;
        end
    end

endmodule

[rtl/core/nmea_rmc_time_date_parser.sv]
// ----------------------------------------------------------------------------
// nmea_rmc_time_date_parser
// rmc sentence time and date extractor, one character per item
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                   item
//   chr      in   ch[7:0], last                             one character
//   stamp    out  ok, hours, minutes, seconds, day, month,  one per sentence
//                 year (7 bits each)
//
// one character item accepted per cycle unless a closing character stalls;
// a closing character passes the input register, may wait there while the
// previous result is pending, and the field tracker update then loads the
// result register, which makes the result valid
// rst_n clears the input and result valids and the sentence control state
// a waiting result stalls only a following last character; other characters
// keep flowing, so the input side stalls only while stamp is stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nmea_rmc_time_date_parser #(
    parameter int MAX_LEN = 127
) (
    input  logic               clk,
    input  logic               rst_n,
    nrmc_stream_if.sink        chr,
    nrmc_stream_if.source      stamp
);
    // input register
    nrmc_pkg::char_t   in_reg;
    logic              in_valid_reg;

    // result register
    nrmc_pkg::result_t out_reg;
    logic              out_valid_reg;

    nrmc_pkg::result_t res;
    logic              fire;

    // the held character is processed unless it closes a sentence and the
    // previous result still waits downstream
    assign fire      = in_valid_reg && (!in_reg.last || !out_valid_reg || stamp.ready);
    assign chr.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chr.ready)
        begin
            in_valid_reg <= chr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chr.ready && chr.valid)
        begin
            in_reg <= chr.payload;
        end
    end

    // sentence state and result logic
    nrmc_field_tracker #(
        .MAX_LEN (MAX_LEN)
    ) u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && in_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (stamp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_reg.last)
        begin
            out_reg <= res;
        end
    end

    assign stamp.valid   = out_valid_reg;
    assign stamp.payload = out_reg;

    // a result only follows a processed last character
    `ASSERT_CLK(a_result_src, clk, rst_n, $rose(out_valid_reg) |-> $past(fire && in_reg.last), "result without a closing character")

    // an invalid result carries all-zero values
    `ASSERT_CLK(a_bad_zero, clk, rst_n, (out_valid_reg && !out_reg.ok) |-> (out_reg.hours == 7'd0 && out_reg.minutes == 7'd0 && out_reg.seconds == 7'd0 && out_reg.day == 7'd0 && out_reg.month == 7'd0 && out_reg.year == 7'd0), "invalid result with nonzero values")

    // a held character that did not advance stays in the input register
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !fire, in_valid_reg && $stable(in_reg), "input register lost a character")

    // a pending result is never overwritten
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !stamp.ready, out_valid_reg && $stable(out_reg), "pending result overwritten")

endmodule
